@@ src/mvna_pkg.sv @@
// ----------------------------------------------------------------------------
// mvna_pkg
// Shared types and constants of the mesh vertex normal accumulator.
// ----------------------------------------------------------------------------
package mvna_pkg;

    // store geometry
    localparam int MAX_VERTICES = 4096;
    localparam int IDX_W        = $clog2(MAX_VERTICES);
    localparam int SUM_W        = 24;
    localparam int POS_W        = 24;

    // datapath widths
    localparam int EDGE_W = POS_W + 1;
    localparam int PROD_W = 2 * EDGE_W;
    localparam int VEC_W  = PROD_W + 1;
    localparam int NORM_W = 16;
    localparam int Q_W    = 15;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FACE  = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef struct packed {
        logic [1:0]              cmd;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } t_in;

    typedef struct packed {
        logic                     kind;
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     degenerate;
    } t_out;

    // unit normal handed from the normalizer to the sequencer
    typedef struct packed {
        logic signed [NORM_W-1:0] x;
        logic signed [NORM_W-1:0] y;
        logic signed [NORM_W-1:0] z;
        logic                     degenerate;
    } t_norm;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOAD, S_PRD_A, S_PRD_B, S_PRD_C, S_PCAP, S_EDGE,
        S_MUL, S_CROSS, S_QRD, S_QCAP, S_USTART, S_UNIT, S_SRD, S_SWR, S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        U_IDLE, U_SHIFT, U_SQ, U_SQRT, U_DIV, U_DONE
    } t_ustate;

endpackage

@@ src/mvna_ram.sv @@
// ----------------------------------------------------------------------------
// mvna_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mvna_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and read-before-write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        r_rdata <= mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mvna_unit.sv @@
// ----------------------------------------------------------------------------
// mvna_unit
// Scales a signed vector to unit length in Q2.14: pre-shift, sum of squares,
// bit-serial square root and three parallel restoring dividers.
// ----------------------------------------------------------------------------
module mvna_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [mvna_pkg::VEC_W-1:0] i_vec [3],
    output logic                          o_done,
    output mvna_pkg::t_norm               o_norm
);
    import mvna_pkg::*;

    localparam int MAG_W = VEC_W;
    localparam int SQ_W  = 63;
    localparam int LEN_W = 32;
    localparam int DIV_W = LEN_W + Q_W;

    t_ustate r_state, n_state;

    logic [MAG_W-1:0] r_mag [3];
    logic [2:0]       r_neg;
    logic             r_deg;
    logic [59:0]      r_prod;
    logic [SQ_W-1:0]  r_sq;
    logic [SQ_W-1:0]  r_res;
    logic [SQ_W-1:0]  r_bit;
    logic [1:0]       r_cnt;
    logic [3:0]       r_icnt;
    logic [DIV_W-1:0] r_dsr;
    logic [DIV_W-1:0] r_rem [3];
    logic [Q_W-1:0]   r_q [3];

    logic [MAG_W-1:0] w_mag [3];
    logic             w_zero;
    logic             w_big;
    logic [1:0]       w_sel;
    logic [29:0]      w_sq_op;
    logic [SQ_W-1:0]  w_trial;
    logic [LEN_W-1:0] w_len;
    logic [NORM_W-1:0] w_n [3];

    // magnitudes of the incoming vector
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = i_vec[k][VEC_W-1] ? MAG_W'(-i_vec[k]) : MAG_W'(i_vec[k]);
        end
        w_zero = (i_vec[0] == '0) && (i_vec[1] == '0) && (i_vec[2] == '0);
    end

    // any magnitude at or above 2^30
    always_comb begin
        w_big = 1'b0;
        for (int k = 0; k < 3; k++) begin
            w_big = w_big | (|r_mag[k][MAG_W-1:30]);
        end
    end

    assign w_sel   = (r_cnt == 2'd3) ? 2'd0 : r_cnt;
    assign w_sq_op = r_mag[w_sel][29:0];
    assign w_trial = r_res + r_bit;
    assign w_len   = (r_res[LEN_W-1:0] == '0) ? LEN_W'(1) : r_res[LEN_W-1:0];

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= U_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            U_IDLE:  if (i_start) n_state = w_zero ? U_DONE : U_SHIFT;
            U_SHIFT: if (!w_big) n_state = U_SQ;
            U_SQ:    if (r_cnt == 2'd3) n_state = U_SQRT;
            U_SQRT:  if (r_bit == '0) n_state = U_DIV;
            U_DIV:   if (r_icnt == 4'(Q_W - 1)) n_state = U_DONE;
            U_DONE:  n_state = U_IDLE;
            default: n_state = U_IDLE;
        endcase
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            U_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    r_mag[k] <= w_mag[k];
                    r_neg[k] <= i_vec[k][VEC_W-1];
                    r_q[k]   <= '0;
                end
                r_deg <= w_zero;
                r_cnt <= '0;
                r_sq  <= '0;
            end
            U_SHIFT: begin
                if (w_big) begin
                    for (int k = 0; k < 3; k++) begin
                        r_mag[k] <= r_mag[k] >> 1;
                    end
                end
            end
            U_SQ: begin
                r_prod <= w_sq_op * w_sq_op;
                if (r_cnt != 2'd0) begin
                    r_sq <= r_sq + SQ_W'(r_prod);
                end
                r_cnt <= r_cnt + 2'd1;
                r_res <= '0;
                r_bit <= SQ_W'(1) << 62;
            end
            U_SQRT: begin
                if (r_bit != '0) begin
                    if (r_sq >= w_trial) begin
                        r_sq  <= r_sq - w_trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_dsr  <= DIV_W'(w_len) << (Q_W - 1);
                    r_icnt <= '0;
                    for (int k = 0; k < 3; k++) begin
                        r_rem[k] <= (DIV_W'(r_mag[k][29:0]) << (Q_W - 1))
                                    + DIV_W'(w_len >> 1);
                    end
                end
            end
            U_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    if (r_rem[k] >= r_dsr) begin
                        r_rem[k] <= r_rem[k] - r_dsr;
                        r_q[k]   <= {r_q[k][Q_W-2:0], 1'b1};
                    end else begin
                        r_q[k]   <= {r_q[k][Q_W-2:0], 1'b0};
                    end
                end
                r_dsr  <= r_dsr >> 1;
                r_icnt <= r_icnt + 4'd1;
            end
            U_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // sign restore
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_n[k] = r_neg[k] ? -NORM_W'(r_q[k]) : NORM_W'(r_q[k]);
        end
    end

    assign o_done            = (r_state == U_DONE);
    assign o_norm.x          = w_n[0];
    assign o_norm.y          = w_n[1];
    assign o_norm.z          = w_n[2];
    assign o_norm.degenerate = r_deg;

endmodule

@@ src/mesh_vertex_normal_accumulator.sv @@
// ----------------------------------------------------------------------------
// mesh_vertex_normal_accumulator
// Fixed-point vertex normal accumulation over a position store and a
// normal-sum store, with a shared vector normalizer.
// ----------------------------------------------------------------------------
// Load, face and query items are handled one at a time; the time a face or a
// query takes is set by the normalizer (pre-shift of up to 19 steps, 32
// square-root steps, 15 divide steps) and, for a face, the sum store updates;
// a zero-area face or a zero sum skips the normalizer steps. Results come as a
// one-cycle o_strobe and cannot stall. After reset the normal-sum store is
// cleared, one entry a cycle, all 4096 entries, with busy high.
module mesh_vertex_normal_accumulator (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  mvna_pkg::t_in   i_item,
    output logic            busy,
    output logic            o_strobe,
    output mvna_pkg::t_out  o_result
);
    import mvna_pkg::*;

    localparam int ROW_W = 3 * POS_W;
    localparam int SROW_W = 3 * SUM_W;

    t_state r_state, n_state;

    t_in                      r_item;
    logic [IDX_W-1:0]         r_clr;
    logic [1:0]               r_k;
    logic [2:0]               r_mcnt;
    logic [ROW_W-1:0]         r_pa, r_pb;
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [PROD_W-1:0] r_p [6];
    logic signed [VEC_W-1:0]  r_vec [3];
    t_norm                    r_norm;
    t_out                     r_out;

    logic                     w_pwe, w_swe;
    logic [IDX_W-1:0]         w_paddr, w_saddr;
    logic [ROW_W-1:0]         w_pwdata, w_prdata;
    logic [SROW_W-1:0]        w_swdata, w_srdata;
    logic [IDX_W-1:0]         w_corner;
    logic signed [EDGE_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_mul;
    logic                     w_udone;
    t_norm                    w_unorm;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  a,
        input logic signed [NORM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s[SUM_W] != s[SUM_W-1]) begin
            sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

    // stores
    mvna_ram #(.WIDTH(ROW_W), .DEPTH(MAX_VERTICES)) u_pos (
        .i_clk  (i_clk),
        .i_we   (w_pwe),
        .i_addr (w_paddr),
        .i_wdata(w_pwdata),
        .o_rdata(w_prdata)
    );

    mvna_ram #(.WIDTH(SROW_W), .DEPTH(MAX_VERTICES)) u_sum (
        .i_clk  (i_clk),
        .i_we   (w_swe),
        .i_addr (w_saddr),
        .i_wdata(w_swdata),
        .o_rdata(w_srdata)
    );

    mvna_unit u_unit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_state == S_USTART),
        .i_vec  (r_vec),
        .o_done (w_udone),
        .o_norm (w_unorm)
    );

    // current corner of the sum update
    always_comb begin
        unique case (r_k)
            2'd0:    w_corner = r_item.corner_a;
            2'd1:    w_corner = r_item.corner_b;
            default: w_corner = r_item.corner_c;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and store controls
    always_comb begin
        n_state  = r_state;
        w_pwe    = 1'b0;
        w_swe    = 1'b0;
        w_paddr  = r_item.vertex_index;
        w_saddr  = r_item.vertex_index;
        w_pwdata = {r_item.pos_z, r_item.pos_y, r_item.pos_x};
        w_swdata = '0;
        unique case (r_state)
            S_CLEAR: begin
                w_swe   = 1'b1;
                w_saddr = r_clr;
                if (r_clr == {IDX_W{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    unique case (t_cmd'(i_item.cmd))
                        CMD_LOAD:  n_state = S_LOAD;
                        CMD_FACE:  n_state = S_PRD_A;
                        CMD_QUERY: n_state = S_QRD;
                        CMD_NONE:  n_state = S_IDLE;
                    endcase
                end
            end
            S_LOAD: begin
                w_pwe   = 1'b1;
                w_swe   = 1'b1;
                n_state = S_IDLE;
            end
            S_PRD_A: begin
                w_paddr = r_item.corner_a;
                n_state = S_PRD_B;
            end
            S_PRD_B: begin
                w_paddr = r_item.corner_b;
                n_state = S_PRD_C;
            end
            S_PRD_C: begin
                w_paddr = r_item.corner_c;
                n_state = S_PCAP;
            end
            S_PCAP:   n_state = S_EDGE;
            S_EDGE:   n_state = S_MUL;
            S_MUL:    if (r_mcnt == 3'd5) n_state = S_CROSS;
            S_CROSS:  n_state = S_USTART;
            S_QRD:    n_state = S_QCAP;
            S_QCAP:   n_state = S_USTART;
            S_USTART: n_state = S_UNIT;
            S_UNIT: begin
                if (w_udone) n_state = (r_out.kind == KIND_FACE) ? S_SRD : S_EMIT;
            end
            S_SRD: begin
                w_saddr = w_corner;
                n_state = S_SWR;
            end
            S_SWR: begin
                w_saddr  = w_corner;
                w_swe    = 1'b1;
                w_swdata = {sat_add(w_srdata[3*SUM_W-1:2*SUM_W], r_norm.z),
                            sat_add(w_srdata[2*SUM_W-1:SUM_W], r_norm.y),
                            sat_add(w_srdata[SUM_W-1:0], r_norm.x)};
                n_state  = (r_k == 2'd2) ? S_EMIT : S_SRD;
            end
            S_EMIT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // multiplier operand select for the cross product
    always_comb begin
        unique case (r_mcnt)
            3'd0:    begin w_ma = r_e1[1]; w_mb = r_e2[2]; end
            3'd1:    begin w_ma = r_e1[2]; w_mb = r_e2[1]; end
            3'd2:    begin w_ma = r_e1[2]; w_mb = r_e2[0]; end
            3'd3:    begin w_ma = r_e1[0]; w_mb = r_e2[2]; end
            3'd4:    begin w_ma = r_e1[0]; w_mb = r_e2[1]; end
            default: begin w_ma = r_e1[1]; w_mb = r_e2[0]; end
        endcase
    end

    assign w_mul = w_ma * w_mb;

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr <= r_clr + IDX_W'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                r_item   <= i_item;
                r_k      <= '0;
                r_mcnt   <= '0;
                r_out.kind <= (t_cmd'(i_item.cmd) == CMD_FACE) ? KIND_FACE : KIND_VERTEX;
            end
            S_PRD_B: r_pa <= w_prdata;
            S_PRD_C: r_pb <= w_prdata;
            S_PCAP: begin
                for (int k = 0; k < 3; k++) begin
                    r_e1[k] <= EDGE_W'($signed(r_pb[k*POS_W +: POS_W]))
                             - EDGE_W'($signed(r_pa[k*POS_W +: POS_W]));
                    r_e2[k] <= EDGE_W'($signed(w_prdata[k*POS_W +: POS_W]))
                             - EDGE_W'($signed(r_pa[k*POS_W +: POS_W]));
                end
            end
            S_MUL: begin
                r_p[r_mcnt] <= w_mul;
                r_mcnt      <= r_mcnt + 3'd1;
            end
            S_CROSS: begin
                for (int k = 0; k < 3; k++) begin
                    r_vec[k] <= VEC_W'(r_p[2*k]) - VEC_W'(r_p[2*k+1]);
                end
            end
            S_QCAP: begin
                for (int k = 0; k < 3; k++) begin
                    r_vec[k] <= VEC_W'($signed(w_srdata[k*SUM_W +: SUM_W]));
                end
            end
            S_UNIT: begin
                if (w_udone) begin
                    r_norm           <= w_unorm;
                    r_out.norm_x     <= w_unorm.x;
                    r_out.norm_y     <= w_unorm.y;
                    r_out.norm_z     <= w_unorm.z;
                    r_out.degenerate <= w_unorm.degenerate;
                end
            end
            S_SWR: r_k <= r_k + 2'd1;
            default: begin
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_EMIT);
    assign o_result = r_out;

endmodule
